>>> sv/rsp_pkg.sv
// Shared types and codes for the register subframe parser.
// No dependencies; imported by rsp_out_stage and register_subframe_parser.
package rsp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_CMD,
        PH_COUNT,
        PH_REGNUM,
        PH_VALUE,
        PH_ERRVAL,
        PH_BURST
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_REPLY   = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // Command type codes (upper nibble of the command byte)
    localparam logic [3:0] TYPE_READ  = 4'h1;
    localparam logic [3:0] TYPE_ERROR = 4'h3;
    localparam logic [3:0] TYPE_NOP   = 4'h5;

    // Value size codes
    localparam logic [1:0] SIZE_INT8  = 2'd0;
    localparam logic [1:0] SIZE_INT16 = 2'd1;

    localparam int REG_W = 28;

    // One result word
    typedef struct packed {
        logic [2:0]       kind;
        logic [REG_W-1:0] reg_number;
        logic [31:0]      data_value;
        logic [1:0]       value_size;
        logic             count_clamped;
        logic             last_of_run;
    } result_t;

endpackage

>>> sv/register_subframe_parser.sv
// Register subframe parser, top level: byte-wise command parser with a read burst sequencer.
// Depends on rsp_pkg and rsp_out_stage.
//
//  channel  | dir | tdata                                          | tlast         | tuser
//  s_       | in  | [7:0] data_byte                                | last_in_frame | -
//  m_       | out | [27:0] reg_number [59:28] data_value           | last_of_run   | [2:0] kind
//           |     | [61:60] value_size [62] count_clamped [63] 0   |               |
//
// A byte's result (if any) is loaded into the output register at the same edge that
// takes the byte, so bytes flow one per cycle while m_tready is high and no burst runs.
// After the register number byte a read burst holds s_tready low and emits one word per
// register; the single shared 28-bit adder forms base + index, one word a cycle unless stalled.
// Reset (rst_n, async, active low) returns to the command phase with no word pending.
// Stalls on m_tready hold the output word and stop input intake until it drains.
module register_subframe_parser
    import rsp_pkg::*;
#(
    parameter int MAX_REGS      = 64,
    parameter int REG_NUM_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_in_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [27:0] reg_number, [59:28] data_value,
                                   // [61:60] value_size, [62] count_clamped
    output logic        m_tlast,   // last_of_run
    output logic [2:0]  m_tuser    // [2:0] kind
);

    localparam int CNT_W = $clog2(MAX_REGS + 1);

    phase_t           phase_reg, phase_next;
    logic [1:0]       cmd_kind_reg, cmd_kind_next;
    logic [1:0]       size_code_reg, size_code_next;
    logic [CNT_W-1:0] regs_left_reg, regs_left_next;
    logic [REG_W-1:0] base_reg, base_next;
    logic [1:0]       vu_idx_reg, vu_idx_next;
    logic [31:0]      accum_reg, accum_next;
    logic [1:0]       vb_idx_reg, vb_idx_next;
    logic [7:0]       offset_reg, offset_next;
    logic             clamp_reg, clamp_next;
    logic [CNT_W-1:0] burst_idx_reg, burst_idx_next;
    logic [CNT_W-1:0] burst_total_reg, burst_total_next;

    logic             can_load;
    logic             s_accept;
    logic             emit;
    result_t          res;
    result_t          out_word;

    // Shared adder: base plus value offset or burst index
    logic [REG_W-1:0] add_operand;
    logic [REG_W-1:0] reg_sum;

    // Byte decode helpers
    logic [3:0]       cmd_nibble;
    logic [4:0]       vu_shamt;
    logic [REG_W-1:0] base_or;
    logic             vu_done;
    logic [31:0]      accum_or;
    logic             vb_done;
    logic [31:0]      value_ext;
    logic [CNT_W-1:0] cnt_small;
    logic             cnt_small_clamp;
    logic [CNT_W-1:0] cnt_byte;
    logic             cnt_byte_clamp;

    assign s_tready = (phase_reg != PH_BURST) && can_load;
    assign s_accept = s_tvalid && s_tready;

    assign add_operand = (phase_reg == PH_BURST) ? REG_W'(burst_idx_reg) : REG_W'(offset_reg);
    assign reg_sum     = base_reg + add_operand;

    assign cmd_nibble = s_tdata[7:4];

    // Varuint: 7 bits per byte, ends on clear bit 7 or at the byte limit
    assign vu_shamt = {vu_idx_reg, 3'b000} - {3'b000, vu_idx_reg};
    assign base_or  = base_reg | (REG_W'(s_tdata[6:0]) << vu_shamt);
    assign vu_done  = !s_tdata[7] || (({1'b0, vu_idx_reg} + 3'd1) >= 3'(REG_NUM_BYTES));

    // Little-endian value assembly and sign extension
    assign accum_or = accum_reg | (32'(s_tdata) << {vb_idx_reg, 3'b000});
    always_comb
    begin
        case (size_code_reg)
            SIZE_INT8:  vb_done = 1'b1;
            SIZE_INT16: vb_done = (vb_idx_reg >= 2'd1);
            default:    vb_done = (vb_idx_reg == 2'd3);
        endcase
    end

    always_comb
    begin
        case (size_code_reg)
            SIZE_INT8:  value_ext = {{24{accum_or[7]}}, accum_or[7:0]};
            SIZE_INT16: value_ext = {{16{accum_or[15]}}, accum_or[15:0]};
            default:    value_ext = accum_or;
        endcase
    end

    // Count clamping for the command's own count and for a count byte
    always_comb
    begin
        if (8'(s_tdata[1:0]) > 8'(MAX_REGS))
        begin
            cnt_small       = CNT_W'(MAX_REGS);
            cnt_small_clamp = 1'b1;
        end
        else
        begin
            cnt_small       = CNT_W'(s_tdata[1:0]);
            cnt_small_clamp = 1'b0;
        end
        if (s_tdata > 8'(MAX_REGS))
        begin
            cnt_byte       = CNT_W'(MAX_REGS);
            cnt_byte_clamp = 1'b1;
        end
        else
        begin
            cnt_byte       = CNT_W'(s_tdata);
            cnt_byte_clamp = 1'b0;
        end
    end

    // Next state of the parser
    always_comb
    begin
        phase_next       = phase_reg;
        cmd_kind_next    = cmd_kind_reg;
        size_code_next   = size_code_reg;
        regs_left_next   = regs_left_reg;
        base_next        = base_reg;
        vu_idx_next      = vu_idx_reg;
        accum_next       = accum_reg;
        vb_idx_next      = vb_idx_reg;
        offset_next      = offset_reg;
        clamp_next       = clamp_reg;
        burst_idx_next   = burst_idx_reg;
        burst_total_next = burst_total_reg;

        if (phase_reg == PH_BURST)
        begin
            if (can_load)
            begin
                burst_idx_next = burst_idx_reg + CNT_W'(1);
                if (burst_idx_reg == burst_total_reg - CNT_W'(1))
                begin
                    phase_next = PH_CMD;
                end
            end
        end
        else if (s_accept)
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    if (cmd_nibble <= {2'b00, TYPE_ERROR[1:0]})
                    begin
                        cmd_kind_next  = cmd_nibble[1:0];
                        size_code_next = s_tdata[3:2];
                        base_next      = '0;
                        vu_idx_next    = '0;
                        offset_next    = '0;
                        accum_next     = '0;
                        vb_idx_next    = '0;
                        if (cmd_nibble == TYPE_ERROR || s_tdata[1:0] != 2'b00)
                        begin
                            regs_left_next = cnt_small;
                            clamp_next     = cnt_small_clamp;
                            phase_next     = PH_REGNUM;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    regs_left_next = cnt_byte;
                    clamp_next     = cnt_byte_clamp;
                    phase_next     = PH_REGNUM;
                end
                PH_REGNUM:
                begin
                    base_next = base_or;
                    if (vu_done)
                    begin
                        vu_idx_next = '0;
                        if (cmd_kind_reg == TYPE_ERROR[1:0])
                        begin
                            phase_next = PH_ERRVAL;
                        end
                        else if (cmd_kind_reg == TYPE_READ[1:0])
                        begin
                            regs_left_next   = '0;
                            burst_idx_next   = '0;
                            burst_total_next = regs_left_reg;
                            phase_next       = (regs_left_reg != '0) ? PH_BURST : PH_CMD;
                        end
                        else
                        begin
                            phase_next = (regs_left_reg != '0) ? PH_VALUE : PH_CMD;
                        end
                    end
                    else
                    begin
                        vu_idx_next = vu_idx_reg + 2'd1;
                    end
                end
                PH_VALUE:
                begin
                    if (vb_done)
                    begin
                        offset_next    = offset_reg + 8'd1;
                        accum_next     = '0;
                        vb_idx_next    = '0;
                        regs_left_next = regs_left_reg - CNT_W'(1);
                        if (regs_left_reg == CNT_W'(1))
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                    else
                    begin
                        accum_next  = accum_or;
                        vb_idx_next = vb_idx_reg + 2'd1;
                    end
                end
                PH_ERRVAL:
                begin
                    phase_next = PH_CMD;
                end
                default:
                begin
                    phase_next = PH_CMD;
                end
            endcase

            // End of frame drops any partial subframe; a started burst still runs
            if (s_tlast)
            begin
                if (phase_next != PH_BURST)
                begin
                    phase_next = PH_CMD;
                end
                regs_left_next = '0;
                vu_idx_next    = '0;
                accum_next     = '0;
                vb_idx_next    = '0;
                offset_next    = '0;
            end
        end
    end

    // Result word and load strobe
    always_comb
    begin
        emit              = 1'b0;
        res.kind          = KIND_UNKNOWN;
        res.reg_number    = reg_sum;
        res.data_value    = 32'(s_tdata);
        res.value_size    = size_code_reg;
        res.count_clamped = clamp_reg;
        res.last_of_run   = 1'b1;
        case (phase_reg)
            PH_BURST:
            begin
                emit            = can_load;
                res.kind        = KIND_READ;
                res.data_value  = '0;
                res.last_of_run = (burst_idx_reg == burst_total_reg - CNT_W'(1));
            end
            PH_CMD:
            begin
                emit              = s_accept && (cmd_nibble > {2'b00, TYPE_ERROR[1:0]})
                                    && (cmd_nibble != TYPE_NOP);
                res.kind          = KIND_UNKNOWN;
                res.reg_number    = '0;
                res.value_size    = s_tdata[3:2];
                res.count_clamped = 1'b0;
            end
            PH_VALUE:
            begin
                emit           = s_accept && vb_done;
                res.kind       = {1'b0, cmd_kind_reg};
                res.data_value = value_ext;
            end
            PH_ERRVAL:
            begin
                emit       = s_accept;
                res.kind   = KIND_ERROR;
                res.reg_number = base_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CMD;
            cmd_kind_reg    <= '0;
            size_code_reg   <= '0;
            regs_left_reg   <= '0;
            base_reg        <= '0;
            vu_idx_reg      <= '0;
            accum_reg       <= '0;
            vb_idx_reg      <= '0;
            offset_reg      <= '0;
            clamp_reg       <= 1'b0;
            burst_idx_reg   <= '0;
            burst_total_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cmd_kind_reg    <= cmd_kind_next;
            size_code_reg   <= size_code_next;
            regs_left_reg   <= regs_left_next;
            base_reg        <= base_next;
            vu_idx_reg      <= vu_idx_next;
            accum_reg       <= accum_next;
            vb_idx_reg      <= vb_idx_next;
            offset_reg      <= offset_next;
            clamp_reg       <= clamp_next;
            burst_idx_reg   <= burst_idx_next;
            burst_total_reg <= burst_total_next;
        end
    end

    rsp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {1'b0, out_word.count_clamped, out_word.value_size,
                      out_word.data_value, out_word.reg_number};
    assign m_tlast = out_word.last_of_run;
    assign m_tuser = out_word.kind;

    // Burst index stays inside the run
    a_burst_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BURST) |-> (burst_idx_reg < burst_total_reg))
        else $error("burst index out of range");

    // Count never exceeds the clamp limit
    a_regs_left: assert property (@(posedge clk) disable iff (!rst_n)
        regs_left_reg <= CNT_W'(MAX_REGS))
        else $error("register count above limit");

    // Value phase always has registers left
    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |-> (regs_left_reg != '0))
        else $error("value phase with no registers left");

    // Frame end returns to command phase unless a read burst was started
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> (phase_reg == PH_CMD || phase_reg == PH_BURST))
        else $error("parser not reset at frame end");

endmodule

>>> sv/rsp_out_stage.sv
// Output holding register for result words, master-side stream handshake.
// Depends on rsp_pkg (result_t).
module rsp_out_stage
    import rsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or drained in this cycle
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A held word must not be overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !load)
        else $error("result overwritten while stalled");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

>>> bench/register_subframe_parser_tb.sv
// Testbench for register_subframe_parser: drives payload bytes on the s_ stream, predicts
// every result word with a behavioral parser and checks the m_ stream word by word.
// Depends on rsp_pkg and the register_subframe_parser RTL.
module register_subframe_parser_tb
    import rsp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REGS      = 64;
    localparam int REG_NUM_BYTES = 4;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_ITEMS  = 210;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    register_subframe_parser #(
        .MAX_REGS      (MAX_REGS),
        .REG_NUM_BYTES (REG_NUM_BYTES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Parser state mirrored by the predictor
    phase_t      ph        = PH_CMD;
    logic [2:0]  sub_kind  = '0;
    logic [1:0]  sub_size  = '0;
    logic [7:0]  regs_todo = '0;
    logic [27:0] reg_base  = '0;
    logic [1:0]  vu_idx    = '0;
    logic [31:0] val_acc   = '0;
    logic [1:0]  val_idx   = '0;
    logic [7:0]  val_off   = '0;
    logic        clamped   = 1'b0;

    result_t     pending_results[$];
    logic [8:0]  frame_bytes[$];     // {last_in_frame, data_byte}
    int          run_len;
    int          err_cnt  = 0;
    int          sent_cnt = 0;
    logic        idle_on  = 1'b1;
    logic        hold_req = 1'b0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task add_result(input logic [2:0] k, input logic [27:0] rn, input logic [31:0] rv,
                    input logic [1:0] sz, input logic cl);
        result_t r;
        r.kind          = k;
        r.reg_number    = rn;
        r.data_value    = rv;
        r.value_size    = sz;
        r.count_clamped = cl;
        r.last_of_run   = 1'b0;
        pending_results.push_back(r);
        run_len++;
    endtask

    task load_count(input logic [7:0] c);
        if (c > MAX_REGS)
        begin
            regs_todo = 8'(MAX_REGS);
            clamped   = 1'b1;
        end
        else
        begin
            regs_todo = c;
            clamped   = 1'b0;
        end
    endtask

    task parse_byte(input logic [7:0] b, input logic last);
        logic [3:0]  ctype;
        logic [27:0] ofs;
        logic [31:0] v;
        int          nbytes;
        result_t     r;
        run_len = 0;
        case (ph)
            PH_CMD:
            begin
                ctype = b[7:4];
                if (ctype > TYPE_ERROR && ctype != TYPE_NOP)
                    add_result(KIND_UNKNOWN, '0, {24'd0, b}, b[3:2], 1'b0);
                else if (ctype != TYPE_NOP)
                begin
                    sub_kind = {1'b0, ctype[1:0]};
                    sub_size = b[3:2];
                    reg_base = '0;
                    vu_idx   = '0;
                    val_off  = '0;
                    val_acc  = '0;
                    val_idx  = '0;
                    // error subframes never take a count byte
                    if (ctype == TYPE_ERROR || b[1:0] != 2'd0)
                    begin
                        load_count({6'd0, b[1:0]});
                        ph = PH_REGNUM;
                    end
                    else
                        ph = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                load_count(b);
                ph = PH_REGNUM;
            end
            PH_REGNUM:
            begin
                reg_base = reg_base | ({21'd0, b[6:0]} << (7 * vu_idx));
                // varuint stops on a clear continue bit or at its byte limit
                if (!b[7] || int'(vu_idx) + 1 >= REG_NUM_BYTES)
                begin
                    vu_idx = '0;
                    if (sub_kind == KIND_ERROR)
                        ph = PH_ERRVAL;
                    else if (sub_kind == KIND_READ)
                    begin
                        for (int i = 0; i < regs_todo; i++)
                        begin
                            ofs = 28'(i);
                            add_result(KIND_READ, reg_base + ofs, '0, sub_size, clamped);
                        end
                        regs_todo = '0;
                        ph = PH_CMD;
                    end
                    else
                        ph = (regs_todo != 0) ? PH_VALUE : PH_CMD;
                end
                else
                    vu_idx = vu_idx + 2'd1;
            end
            PH_VALUE:
            begin
                nbytes = (sub_size == SIZE_INT8) ? 1 : (sub_size == SIZE_INT16) ? 2 : 4;
                val_acc = val_acc | ({24'd0, b} << (8 * val_idx));
                if (int'(val_idx) + 1 >= nbytes)
                begin
                    v = val_acc;
                    if (sub_size == SIZE_INT8)
                        v = {{24{v[7]}}, v[7:0]};
                    else if (sub_size == SIZE_INT16)
                        v = {{16{v[15]}}, v[15:0]};
                    add_result(sub_kind, reg_base + {20'd0, val_off}, v, sub_size, clamped);
                    val_off = val_off + 8'd1;
                    val_acc = '0;
                    val_idx = '0;
                    if (regs_todo > 0)
                        regs_todo = regs_todo - 8'd1;
                    if (regs_todo == 0)
                        ph = PH_CMD;
                end
                else
                    val_idx = val_idx + 2'd1;
            end
            PH_ERRVAL:
            begin
                add_result(KIND_ERROR, reg_base, {24'd0, b}, sub_size, clamped);
                ph = PH_CMD;
            end
            default:
                ph = PH_CMD;
        endcase

        // end of frame drops any partial subframe
        if (last)
        begin
            ph        = PH_CMD;
            regs_todo = '0;
            vu_idx    = '0;
            val_acc   = '0;
            val_idx   = '0;
            val_off   = '0;
        end
        if (run_len > 0)
        begin
            r = pending_results.pop_back();
            r.last_of_run = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // Byte source
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task put_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        parse_byte(b, l);
        sent_cnt++;
    endtask

    task send_frame_bytes();
        logic [8:0] w;
        while (frame_bytes.size() != 0)
        begin
            w = frame_bytes.pop_front();
            put_byte(w[7:0], w[8]);
        end
    endtask

    task mark_frame_end();
        logic [8:0] w;
        if (frame_bytes.size() != 0)
        begin
            w = frame_bytes.pop_back();
            w[8] = 1'b1;
            frame_bytes.push_back(w);
        end
    endtask

    // Sender goes quiet until every predicted word has been taken
    task wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // One well-formed subframe with random content
    task add_subframe();
        int         pick;
        int         r2;
        int         nb;
        int         nvals;
        int         vbytes;
        logic [3:0] t;
        logic [1:0] sz;
        logic [1:0] field;
        logic [7:0] cnt;
        logic [6:0] low7;
        logic       cont;
        pick = $urandom_range(0, 99);
        sz   = 2'($urandom_range(0, 3));
        if (pick < 4)
        begin
            frame_bytes.push_back({1'b0, TYPE_NOP, 4'($urandom_range(0, 15))});
            return;
        end
        if (pick < 9)
        begin
            t = 4'($urandom_range(4, 15));
            if (t == TYPE_NOP)
                t = 4'h4;
            frame_bytes.push_back({1'b0, t, 4'($urandom_range(0, 15))});
            return;
        end
        t = (pick < 40) ? 4'h0 : (pick < 60) ? TYPE_READ : (pick < 85) ? 4'h2 : TYPE_ERROR;
        field = 2'($urandom_range(0, 3));
        cnt   = {6'd0, field};
        if (t != TYPE_ERROR)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                field = 2'($urandom_range(1, 3));
                cnt   = {6'd0, field};
            end
            else
            begin
                field = 2'd0;
                r2 = $urandom_range(0, 99);
                if (r2 < 15)
                    cnt = 8'd0;
                else if (r2 < 85)
                    cnt = 8'($urandom_range(1, 8));
                else
                begin
                    // big counts, near and above the clamp
                    cnt = 8'($urandom_range(62, 255));
                    if (t != TYPE_READ)
                        sz = SIZE_INT8;
                end
            end
        end
        frame_bytes.push_back({1'b0, t, sz, field});
        if (t != TYPE_ERROR && field == 2'd0)
            frame_bytes.push_back({1'b0, cnt});

        // register number, sometimes with an over-long varuint
        nb = $urandom_range(1, REG_NUM_BYTES);
        for (int i = 0; i < nb; i++)
        begin
            low7 = 7'($urandom_range(0, 127));
            cont = (i < nb - 1) || (nb == REG_NUM_BYTES && $urandom_range(0, 3) == 0);
            frame_bytes.push_back({1'b0, cont, low7});
        end

        if (t == TYPE_ERROR)
            frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        else if (t != TYPE_READ)
        begin
            nvals  = (cnt > MAX_REGS) ? MAX_REGS : int'(cnt);
            vbytes = (sz == SIZE_INT8) ? 1 : (sz == SIZE_INT16) ? 2 : 4;
            repeat (nvals * vbytes) frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
    endtask

    // ---------------------------------------------------------------
    // Word sink and checker
    // ---------------------------------------------------------------
    initial
    begin : sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && idle_on && $urandom_range(0, 3) == 0)
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected word: kind %0d reg_number %0h data_value %0h",
                       m_tuser, m_tdata[27:0], m_tdata[59:28]);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[27:0] !== want.reg_number)
                begin
                    $error("reg_number: expected %0h, actual %0h",
                           want.reg_number, m_tdata[27:0]);
                    err_cnt++;
                end
                if (m_tdata[59:28] !== want.data_value)
                begin
                    $error("data_value: expected %0h, actual %0h",
                           want.data_value, m_tdata[59:28]);
                    err_cnt++;
                end
                if (m_tdata[61:60] !== want.value_size)
                begin
                    $error("value_size: expected %0d, actual %0d",
                           want.value_size, m_tdata[61:60]);
                    err_cnt++;
                end
                if (m_tdata[62] !== want.count_clamped)
                begin
                    $error("count_clamped: expected %0b, actual %0b",
                           want.count_clamped, m_tdata[62]);
                    err_cnt++;
                end
                if (m_tlast !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Field extremes, every command type and the corner cases of the parser
    task test_directed();
        logic [8:0] seq [24];
        seq = '{
            9'h050,                             // nop
            9'h0F7,                             // unknown type
            9'h001, 9'h000, 9'h080,             // write int8, reg 0, value -128
            9'h025, 9'h07F, 9'h000, 9'h080,     // reply int16, reg 127, value -32768
            9'h010, 9'h0FF,                     // read, count byte 255 -> clamped
            9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,     // over-long varuint, top register, wraps
            9'h03C, 9'h000, 9'h0FF,             // error report, byte 0xFF
            9'h000, 9'h000, 9'h012,             // write with zero count: no word
            9'h00E, 9'h001, 9'h111              // frame ends mid-value: dropped
        };
        foreach (seq[i])
            frame_bytes.push_back(seq[i]);
        send_frame_bytes();
    endtask

    // Sink holds off for a long stretch while bytes keep coming
    task test_backpressure();
        hold_req = 1'b1;
        frame_bytes.push_back({1'b0, TYPE_READ, SIZE_INT16, 2'd3});
        frame_bytes.push_back(9'h005);
        repeat (8) add_subframe();
        mark_frame_end();
        send_frame_bytes();
    endtask

    task test_random_frames();
        int goal;
        int keep;
        goal = sent_cnt + RANDOM_ITEMS;
        while (sent_cnt < goal)
        begin
            // some frames run with no idling on either side
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    frame_bytes.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
            end
            else
            begin
                repeat ($urandom_range(1, 3)) add_subframe();
                if ($urandom_range(0, 6) == 0)
                begin
                    keep = $urandom_range(1, frame_bytes.size());
                    while (frame_bytes.size() > keep)
                        void'(frame_bytes.pop_back());
                end
            end
            if ($urandom_range(0, 9) != 0)
                mark_frame_end();
            send_frame_bytes();
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Sequencing and end of run
    // ---------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_results_drained();
        test_backpressure();
        wait_results_drained();
        test_random_frames();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

endmodule
